FILE: rtl/nfd_pkg.sv
// shared constants, result-queue entry type and glyph lookup for the despeckle filter
// no dependencies; used by every module of the block
package nfd_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int WIDTH_W     = 6;
  localparam int HEIGHT_W    = 13;
  localparam int LEVEL_W     = 4;
  localparam int GLYPH_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [LEVEL_W-1:0]    LEVEL_MAX    = LEVEL_W'(9);
  localparam logic [CFG_IDX_W-1:0]  REG_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [WIDTH_W-1:0]    WIDTH_RESET  = WIDTH_W'(32);
  localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET = HEIGHT_W'(1);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               row_end;
    logic               frame_end;
    logic               run_last;
  } job_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    case (lvl)
      4'd0:    g = 8'h20;  // space
      4'd1:    g = 8'h2E;  // .
      4'd2:    g = 8'h27;  // quote
      4'd3:    g = 8'h3A;  // :
      4'd4:    g = 8'h7E;  // ~
      4'd5:    g = 8'h2A;  // *
      4'd6:    g = 8'h3D;  // =
      4'd7:    g = 8'h2B;  // +
      4'd8:    g = 8'h25;  // %
      default: g = 8'h23;  // #
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/nfd_front.sv
// front end: pixel intake, line stores, neighbour window, despeckle decision, row drain
// depends on nfd_pkg; feeds result entries into nfd_queue
module nfd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nfd_pkg::LEVEL_W-1:0]   in_pixel,
  input  logic                          cfg_we,
  input  logic [nfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                          q_push,
  output nfd_pkg::job_t                 q_data,
  input  logic                          q_full
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PRIME    = 3'd1;
  localparam logic [2:0] S_EVAL     = 3'd2;
  localparam logic [2:0] S_DRAIN_RD = 3'd3;
  localparam logic [2:0] S_DRAIN_WR = 3'd4;

  function automatic logic far_apart(input logic [nfd_pkg::LEVEL_W-1:0] a,
                                     input logic [nfd_pkg::LEVEL_W-1:0] b);
    logic [nfd_pkg::LEVEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > nfd_pkg::LEVEL_W'(1);
  endfunction

  logic [2:0]                     state_r, state_nxt;
  logic [nfd_pkg::WIDTH_W-1:0]    width_r;
  logic [nfd_pkg::HEIGHT_W-1:0]   height_r;
  logic [nfd_pkg::COL_W-1:0]      col_r;
  logic [nfd_pkg::ROW_W-1:0]      row_r;
  logic [nfd_pkg::COL_W-1:0]      drain_idx_r;
  logic                           drain_odd_r;
  logic [nfd_pkg::LEVEL_W-1:0]    px_r;
  logic [nfd_pkg::LEVEL_W-1:0]    win_l_r, win_c_r;

  logic [nfd_pkg::LEVEL_W-1:0]    even_mem [nfd_pkg::MAX_WIDTH];
  logic [nfd_pkg::LEVEL_W-1:0]    odd_mem  [nfd_pkg::MAX_WIDTH];
  logic [nfd_pkg::LEVEL_W-1:0]    even_rd_r, odd_rd_r;

  logic [nfd_pkg::WIDTH_W-1:0]    w_eff;
  logic [nfd_pkg::HEIGHT_W-1:0]   h_eff;
  logic                           last_col, last_row, drain_last, interior, has_out;
  logic                           accept, eval_go;
  logic                           cur_odd;
  logic                           cur_re, cur_we, prev_re;
  logic [nfd_pkg::COL_W-1:0]      cur_addr, prev_addr;
  logic                           even_re, even_we, odd_re, odd_we;
  logic [nfd_pkg::COL_W-1:0]      even_addr, odd_addr;
  logic [nfd_pkg::LEVEL_W-1:0]    cur_rd, prev_rd;
  logic [nfd_pkg::LEVEL_W+2-1:0]  nb_sum;
  logic [nfd_pkg::LEVEL_W-1:0]    avg, eval_level;
  logic [nfd_pkg::LEVEL_W-1:0]    px_sat;

  // out-of-range register values clamp
  always_comb begin
    if (width_r == '0) begin
      w_eff = nfd_pkg::WIDTH_W'(1);
    end else if (width_r > nfd_pkg::WIDTH_W'(nfd_pkg::MAX_WIDTH)) begin
      w_eff = nfd_pkg::WIDTH_W'(nfd_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = nfd_pkg::HEIGHT_W'(1);
    end else if (height_r > nfd_pkg::HEIGHT_W'(nfd_pkg::MAX_HEIGHT)) begin
      h_eff = nfd_pkg::HEIGHT_W'(nfd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign px_sat     = (in_pixel > nfd_pkg::LEVEL_MAX) ? nfd_pkg::LEVEL_MAX : in_pixel;
  assign last_col   = (nfd_pkg::WIDTH_W'(col_r) + nfd_pkg::WIDTH_W'(1)) == w_eff;
  assign last_row   = (nfd_pkg::HEIGHT_W'(row_r) + nfd_pkg::HEIGHT_W'(1)) == h_eff;
  assign drain_last = (nfd_pkg::WIDTH_W'(drain_idx_r) + nfd_pkg::WIDTH_W'(1)) == w_eff;
  assign has_out    = (row_r != '0);
  // output row is never the last one, so only top row and side columns are border
  assign interior   = (row_r > nfd_pkg::ROW_W'(1)) && (col_r != '0) && !last_col;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign eval_go  = (state_r == S_EVAL) && !(has_out && q_full);

  // current-row store by row parity
  assign cur_odd = ((state_r == S_DRAIN_RD) || (state_r == S_DRAIN_WR)) ? drain_odd_r
                                                                         : row_r[0];
  assign cur_rd  = cur_odd ? odd_rd_r : even_rd_r;
  assign prev_rd = cur_odd ? even_rd_r : odd_rd_r;

  always_comb begin
    cur_re    = 1'b0;
    cur_we    = 1'b0;
    prev_re   = 1'b0;
    cur_addr  = col_r;
    prev_addr = col_r + nfd_pkg::COL_W'(1);
    case (state_r)
      S_IDLE: begin
        cur_re  = accept;
        prev_re = accept;
        if (col_r == '0) begin
          prev_addr = '0;
        end
      end
      S_PRIME: begin
        prev_re   = 1'b1;
        prev_addr = nfd_pkg::COL_W'(1);
      end
      S_EVAL: begin
        cur_we = eval_go;
      end
      S_DRAIN_RD: begin
        cur_re   = 1'b1;
        cur_addr = drain_idx_r;
      end
      default: begin
      end
    endcase
  end

  assign even_re   = cur_odd ? prev_re : cur_re;
  assign odd_re    = cur_odd ? cur_re : prev_re;
  assign even_we   = !cur_odd && cur_we;
  assign odd_we    = cur_odd && cur_we;
  assign even_addr = cur_odd ? prev_addr : cur_addr;
  assign odd_addr  = cur_odd ? cur_addr : prev_addr;

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[even_addr] <= px_r;
    end
    if (even_re) begin
      even_rd_r <= even_mem[even_addr];
    end
    if (odd_we) begin
      odd_mem[odd_addr] <= px_r;
    end
    if (odd_re) begin
      odd_rd_r <= odd_mem[odd_addr];
    end
  end

  // up = cur store before overwrite, down = new pixel, left from window, right from prev store
  assign nb_sum = (nfd_pkg::LEVEL_W+2)'(cur_rd) + (nfd_pkg::LEVEL_W+2)'(px_r)
                + (nfd_pkg::LEVEL_W+2)'(win_l_r) + (nfd_pkg::LEVEL_W+2)'(prev_rd)
                + (nfd_pkg::LEVEL_W+2)'(2);
  assign avg    = nb_sum[nfd_pkg::LEVEL_W+2-1:2];

  always_comb begin
    eval_level = win_c_r;
    if (interior && far_apart(win_c_r, cur_rd) && far_apart(win_c_r, px_r) &&
        far_apart(win_c_r, win_l_r) && far_apart(win_c_r, prev_rd)) begin
      eval_level = avg;
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_data = '{level: eval_level, row_end: last_col, frame_end: 1'b0,
               run_last: !(last_col && last_row)};
    if (state_r == S_EVAL) begin
      q_push = eval_go && has_out;
    end else if (state_r == S_DRAIN_WR) begin
      q_push = !q_full;
      q_data = '{level: cur_rd, row_end: drain_last, frame_end: drain_last,
                 run_last: drain_last};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (col_r == '0) ? S_PRIME : S_EVAL;
        end
      end
      S_PRIME: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (eval_go) begin
          state_nxt = (last_col && last_row) ? S_DRAIN_RD : S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        state_nxt = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        if (!q_full) begin
          state_nxt = drain_last ? S_IDLE : S_DRAIN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= nfd_pkg::WIDTH_RESET;
      height_r    <= nfd_pkg::HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      drain_idx_r <= '0;
      drain_odd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == nfd_pkg::REG_WIDTH) begin
          width_r <= cfg_wdata[nfd_pkg::WIDTH_W-1:0];
        end else begin
          height_r <= cfg_wdata;
        end
        col_r <= '0;
        row_r <= '0;
      end else if (eval_go) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + nfd_pkg::ROW_W'(1);
        end else begin
          col_r <= col_r + nfd_pkg::COL_W'(1);
        end
      end
      if (eval_go) begin
        drain_idx_r <= '0;
        drain_odd_r <= row_r[0];
      end else if ((state_r == S_DRAIN_WR) && !q_full) begin
        drain_idx_r <= drain_idx_r + nfd_pkg::COL_W'(1);
      end
    end
  end

  // pixel and neighbour window are payload
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= px_sat;
    end
    if (state_r == S_PRIME) begin
      win_c_r <= prev_rd;
    end else if (eval_go) begin
      win_l_r <= win_c_r;
      win_c_r <= prev_rd;
    end
  end

endmodule

FILE: rtl/nfd_queue.sv
// short result queue between front and back ends
// depends on nfd_pkg for the entry type and depth
module nfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nfd_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output nfd_pkg::job_t pop_data,
  output logic          empty
);

  nfd_pkg::job_t               mem_r [nfd_pkg::QUEUE_DEPTH];
  logic [nfd_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [nfd_pkg::QPTR_W:0]    count_r;

  assign full     = (count_r == (nfd_pkg::QPTR_W+1)'(nfd_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + nfd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + nfd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (nfd_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (nfd_pkg::QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/nfd_back.sv
// back end: takes queue entries, looks up the glyph and holds the result register
// depends on nfd_pkg for the entry type and glyph table
module nfd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  nfd_pkg::job_t                 q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nfd_pkg::LEVEL_W-1:0]   out_level,
  output logic [nfd_pkg::GLYPH_W-1:0]   out_glyph,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  output logic                          out_run_last
);

  logic                        valid_r;
  logic [nfd_pkg::LEVEL_W-1:0] level_r;
  logic [nfd_pkg::GLYPH_W-1:0] glyph_r;
  logic                        row_end_r, frame_end_r, run_last_r;

  assign q_pop = !q_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      level_r     <= q_data.level;
      glyph_r     <= nfd_pkg::glyph_of(q_data.level);
      row_end_r   <= q_data.row_end;
      frame_end_r <= q_data.frame_end;
      run_last_r  <= q_data.run_last;
    end
  end

  assign out_valid     = valid_r;
  assign out_level     = level_r;
  assign out_glyph     = glyph_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;
  assign out_run_last  = run_last_r;

endmodule

FILE: rtl/four_neighbour_despeckle_filter.sv
// top level of the four-neighbour despeckle filter
// depends on nfd_pkg, nfd_front, nfd_queue and nfd_back
//
// Streams digit pixels (0..9, larger values saturate to 9) in raster order for a frame of
// frame_width x frame_height (register 0 and 1 on the cfg port; 0 acts as 1, widths above 32
// act as 32, heights above 4096 act as 4096). Any register write restarts the frame; write only
// while the block is idle. Results lag one row: each transfer of a pixel in row r >= 1 yields
// the filtered pixel of row r-1 at the same column, and the last pixel of the frame also
// drains the whole last row unchanged. An interior pixel whose four original neighbours all
// differ from it by more than 1 becomes (sum+2)>>2 of those neighbours; border pixels pass
// through. Each result carries its glyph code plus row_end, frame_end and run_last (last result
// caused by the current input). The front end handles one pixel at a time through the single-port
// line stores: a read, an extra read to prime the neighbour window at row start, then the
// write-back, and it takes no new pixel before that is done; the end-of-frame drain reads and
// pushes each last-row pixel in turn. A 4-entry queue and an output register decouple the
// front end from out_ready stalls. No clearing pass after reset.
module four_neighbour_despeckle_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nfd_pkg::LEVEL_W-1:0]    in_pixel,
  // register writes
  input  logic                           cfg_we,
  input  logic [nfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // filtered output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nfd_pkg::LEVEL_W-1:0]    out_level,
  output logic [nfd_pkg::GLYPH_W-1:0]    out_glyph,
  output logic                           out_row_end,
  output logic                           out_frame_end,
  output logic                           out_run_last
);

  // front end to queue
  logic          q_push;
  nfd_pkg::job_t q_push_data;
  logic          q_full;
  // queue to back end
  logic          q_pop;
  nfd_pkg::job_t q_pop_data;
  logic          q_empty;

  // intake, line stores and despeckle decision
  nfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  // results waiting for the back end
  nfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // glyph lookup and output register
  nfd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_level     (out_level),
    .out_glyph     (out_glyph),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule

FILE: test/four_neighbour_despeckle_filter_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the four-neighbour despeckle filter: directed frames, size limits
// and random frames under several idle and stall patterns, checked against a built-in predictor
// depends on nfd_pkg and four_neighbour_despeckle_filter
module four_neighbour_despeckle_filter_test;

  // quiet cycles after the last result before touching the registers or ending,
  // covers a pixel still in the front end that produces no result
  localparam int SETTLE_CYCLES = 16;

  // glyph codes, level 0 in the lowest byte
  localparam logic [10*nfd_pkg::GLYPH_W-1:0] GLYPHS = "#%+=*~:'. ";

  // 4x3 frame, first pixel in the top nibble: the 9 in row 1 is isolated and its
  // average 1.5 must round up, the 0 beside it must see the original 9 on its left
  localparam logic [47:0] SPECKLE_FRAME = 48'h4198_2909_038F;

  typedef struct packed {
    logic [nfd_pkg::LEVEL_W-1:0] level;
    logic [nfd_pkg::GLYPH_W-1:0] glyph;
    logic                        row_end;
    logic                        frame_end;
    logic                        run_last;
  } filtered_pixel_t;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [nfd_pkg::LEVEL_W-1:0]    in_pixel  = '0;
  logic                           cfg_we    = 1'b0;
  logic [nfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [nfd_pkg::LEVEL_W-1:0]    out_level;
  logic [nfd_pkg::GLYPH_W-1:0]    out_glyph;
  logic                           out_row_end;
  logic                           out_frame_end;
  logic                           out_run_last;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;

  // predictor state: two row stores picked by row parity, stream position, registers
  logic [nfd_pkg::LEVEL_W-1:0]  row_store [2][nfd_pkg::MAX_WIDTH];
  int unsigned                  next_col   = 0;
  int unsigned                  next_row   = 0;
  logic [nfd_pkg::WIDTH_W-1:0]  width_reg  = nfd_pkg::WIDTH_RESET;
  logic [nfd_pkg::HEIGHT_W-1:0] height_reg = nfd_pkg::HEIGHT_RESET;

  // filtered pixels still owed by the block, oldest first
  filtered_pixel_t pending_pixels[$];
  filtered_pixel_t seen_pixel;
  filtered_pixel_t want_pixel;

  four_neighbour_despeckle_filter i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  function automatic bit differs_by_2(input int unsigned a, input int unsigned b);
    return (a > b) ? (a - b > 1) : (b - a > 1);
  endfunction

  function automatic void queue_pixel(input int unsigned lvl, input bit row_last,
                                      input bit frame_last);
    filtered_pixel_t p;
    p.level     = nfd_pkg::LEVEL_W'(lvl);
    p.glyph     = GLYPHS[lvl*nfd_pkg::GLYPH_W +: nfd_pkg::GLYPH_W];
    p.row_end   = row_last;
    p.frame_end = frame_last;
    p.run_last  = 1'b0;
    pending_pixels.push_back(p);
  endfunction

  // one pixel transfer: filtered pixel of the row above, plus the last row on the final pixel
  function automatic void predict_pixel(input logic [nfd_pkg::LEVEL_W-1:0] raw);
    int unsigned     w, h, px, c, r, lvl, up, lf, rt, cur, prv, first;
    filtered_pixel_t tail_pixel;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > nfd_pkg::MAX_WIDTH) w = nfd_pkg::MAX_WIDTH;
    h = 32'(height_reg);
    if (h == 0) h = 1;
    if (h > nfd_pkg::MAX_HEIGHT) h = nfd_pkg::MAX_HEIGHT;
    px = 32'(raw);
    if (px > 32'(nfd_pkg::LEVEL_MAX)) px = 32'(nfd_pkg::LEVEL_MAX);
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    cur = r % 2;
    prv = 1 - cur;
    first = pending_pixels.size();
    if (r >= 1) begin
      lvl = 32'(row_store[prv][c]);
      // interior only, all four neighbours from the unfiltered frame
      if (r - 1 != 0 && r - 1 != h - 1 && c != 0 && c + 1 < w) begin
        up = 32'(row_store[cur][c]);
        lf = 32'(row_store[prv][c - 1]);
        rt = 32'(row_store[prv][c + 1]);
        if (differs_by_2(lvl, up) && differs_by_2(lvl, px) &&
            differs_by_2(lvl, lf) && differs_by_2(lvl, rt))
          lvl = (up + px + lf + rt + 2) >> 2;
      end
      queue_pixel(lvl, c + 1 == w, 1'b0);
    end
    row_store[cur][c] = nfd_pkg::LEVEL_W'(px);
    if (c + 1 == w && r + 1 == h) begin
      // last row is all border, it leaves unchanged
      for (int j = 0; j < w; j++)
        queue_pixel(32'(row_store[cur][j]), j + 1 == w, j + 1 == w);
      next_col = 0;
      next_row = 0;
    end else if (c + 1 == w) begin
      next_col = 0;
      next_row = r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
    if (pending_pixels.size() > first) begin
      tail_pixel = pending_pixels.pop_back();
      tail_pixel.run_last = 1'b1;
      pending_pixels.push_back(tail_pixel);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // result side: random stalls and the field checks
  // ---------------------------------------------------------------------------------------

  function automatic void check_field(input string what,
                                      input logic [nfd_pkg::GLYPH_W-1:0] want,
                                      input logic [nfd_pkg::GLYPH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      seen_pixel = {out_level, out_glyph, out_row_end, out_frame_end, out_run_last};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got level %0d glyph %0d",
                 $time, seen_pixel.level, seen_pixel.glyph);
        mismatches++;
      end else begin
        want_pixel = pending_pixels.pop_front();
        check_field("level", nfd_pkg::GLYPH_W'(want_pixel.level),
                    nfd_pkg::GLYPH_W'(seen_pixel.level));
        check_field("glyph", want_pixel.glyph, seen_pixel.glyph);
        check_field("row_end", nfd_pkg::GLYPH_W'(want_pixel.row_end),
                    nfd_pkg::GLYPH_W'(seen_pixel.row_end));
        check_field("frame_end", nfd_pkg::GLYPH_W'(want_pixel.frame_end),
                    nfd_pkg::GLYPH_W'(seen_pixel.frame_end));
        check_field("run_last", nfd_pkg::GLYPH_W'(want_pixel.run_last),
                    nfd_pkg::GLYPH_W'(seen_pixel.run_last));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // pixel side and register writes, all called at a rising edge
  // ---------------------------------------------------------------------------------------

  // random idle cycles, then hold the pixel until its transfer
  task automatic send_pixel(input logic [nfd_pkg::LEVEL_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    predict_pixel(px);
  endtask

  // stop sending until every owed pixel has come out and the front end is quiet
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // any write restarts the frame, so only on an idle block
  task automatic write_reg(input logic [nfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nfd_pkg::CFG_DATA_W-1:0] value);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nfd_pkg::REG_WIDTH)
      width_reg = value[nfd_pkg::WIDTH_W-1:0];
    else if (idx == nfd_pkg::REG_HEIGHT)
      height_reg = value;
    next_col = 0;
    next_row = 0;
  endtask

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // height left at its reset value: one-row frame, results only from the drain;
  // pixels above 9 saturate
  task automatic test_one_row_frame();
    write_reg(nfd_pkg::REG_WIDTH, nfd_pkg::CFG_DATA_W'(2));
    send_pixel(4'hF);
    send_pixel(4'hA);
  endtask

  // isolated pixel replaced with rounding half up, neighbours from the original frame
  task automatic test_isolated_pixels();
    write_reg(nfd_pkg::REG_WIDTH, nfd_pkg::CFG_DATA_W'(4));
    write_reg(nfd_pkg::REG_HEIGHT, nfd_pkg::CFG_DATA_W'(3));
    for (int k = 0; k < 12; k++)
      send_pixel(SPECKLE_FRAME[47 - 4*k -: 4]);
  endtask

  // a write in the middle of a frame restarts it; zero width and height act as one
  task automatic test_frame_restart();
    write_reg(nfd_pkg::REG_HEIGHT, nfd_pkg::CFG_DATA_W'(3));
    write_reg(nfd_pkg::REG_WIDTH, nfd_pkg::CFG_DATA_W'(4));
    for (int k = 0; k < 6; k++)
      send_pixel(nfd_pkg::LEVEL_W'(k * 3));
    // upper data bits set, width field zero
    write_reg(nfd_pkg::REG_WIDTH, 13'h1FC0);
    write_reg(nfd_pkg::REG_HEIGHT, nfd_pkg::CFG_DATA_W'(0));
    send_pixel(4'hF);
    send_pixel(4'h3);
  endtask

  // widest row with the full drain, first rows of the tallest frames through the height limit
  task automatic test_size_limits();
    write_reg(nfd_pkg::REG_WIDTH, nfd_pkg::CFG_DATA_W'(63));
    write_reg(nfd_pkg::REG_HEIGHT, nfd_pkg::CFG_DATA_W'(2));
    repeat (64) send_pixel(nfd_pkg::LEVEL_W'($urandom_range(15)));
    write_reg(nfd_pkg::REG_WIDTH, nfd_pkg::CFG_DATA_W'(1));
    write_reg(nfd_pkg::REG_HEIGHT, nfd_pkg::CFG_DATA_W'(nfd_pkg::MAX_HEIGHT));
    repeat (6) send_pixel(nfd_pkg::LEVEL_W'($urandom_range(15)));
    write_reg(nfd_pkg::REG_WIDTH, nfd_pkg::CFG_DATA_W'(0));
    write_reg(nfd_pkg::REG_HEIGHT, 13'h1FFF);
    repeat (6) send_pixel(nfd_pkg::LEVEL_W'($urandom_range(15)));
  endtask

  // random frames, mostly small and complete, some cut short by a restart,
  // some running straight into the next frame without a write
  task automatic test_random_frames(input int idle_pct, input int stall_pct, input int goal);
    int                          w_val, h_val, ew, eh, cut, mode, sent;
    logic [nfd_pkg::LEVEL_W-1:0] base, px;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    w_val = 1;
    h_val = 1;
    while (sent < goal) begin
      if (sent == 0 || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       w_val = 0;
          1:       w_val = $urandom_range(32, 63);
          2:       w_val = $urandom_range(9, 31);
          default: w_val = $urandom_range(1, 8);
        endcase
        ew = (w_val == 0) ? 1 : (w_val > nfd_pkg::MAX_WIDTH) ? nfd_pkg::MAX_WIDTH : w_val;
        case ($urandom_range(9))
          0:       h_val = 0;
          1:       h_val = $urandom_range(nfd_pkg::MAX_HEIGHT + 1, 8191);
          default: h_val = (ew > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        endcase
        // unused upper bits of the width write carry noise
        write_reg(nfd_pkg::REG_WIDTH, {7'($urandom_range(127)), 6'(w_val)});
        write_reg(nfd_pkg::REG_HEIGHT, nfd_pkg::CFG_DATA_W'(h_val));
      end
      ew = (w_val == 0) ? 1 : (w_val > nfd_pkg::MAX_WIDTH) ? nfd_pkg::MAX_WIDTH : w_val;
      eh = (h_val == 0) ? 1 : (h_val > nfd_pkg::MAX_HEIGHT) ? nfd_pkg::MAX_HEIGHT : h_val;
      if (eh > 6)
        cut = $urandom_range(1, 3 * ew);
      else if ($urandom_range(5) == 0)
        cut = $urandom_range(1, ew * eh);
      else
        cut = ew * eh;
      // keep the phase near its pixel budget
      if (cut > goal - sent)
        cut = goal - sent;
      // flat background with spikes, a base level with small jitter and spikes, or plain noise
      mode = $urandom_range(2);
      base = nfd_pkg::LEVEL_W'($urandom_range(9));
      for (int k = 0; k < cut; k++) begin
        case (mode)
          0:       px = nfd_pkg::LEVEL_W'($urandom_range(15));
          1:       px = ($urandom_range(3) == 0) ? nfd_pkg::LEVEL_W'($urandom_range(15)) : base;
          default: px = ($urandom_range(7) == 0) ? nfd_pkg::LEVEL_W'($urandom_range(15)) :
                                                   nfd_pkg::LEVEL_W'(base + $urandom_range(1));
        endcase
        send_pixel(px);
      end
      sent += cut;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_one_row_frame();
    test_isolated_pixels();
    test_frame_restart();
    test_size_limits();
    test_random_frames(0, 0, 20);
    test_random_frames(46, 0, 20);
    test_random_frames(0, 46, 20);
    test_random_frames(16, 16, 20);
    hold_until_drained();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
